@@ src/bctd_pkg.sv @@
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared types, codes and arithmetic helpers of the BC texture block decoder.
// ----------------------------------------------------------------------------
package bctd_pkg;

  // Texture format codes held in the format register
  typedef enum logic [3:0] {
    FMT_L8    = 4'd0,
    FMT_A8    = 4'd1,
    FMT_R8    = 4'd2,
    FMT_L8A8  = 4'd3,
    FMT_RG8   = 4'd4,
    FMT_RGBA8 = 4'd5,
    FMT_BGRA8 = 4'd6,
    FMT_BC1   = 4'd7,
    FMT_BC3   = 4'd8,
    FMT_BC4   = 4'd9,
    FMT_BC5   = 4'd10
  } fmt_e;

  // Divisor applied to a weighted palette sum
  typedef enum logic [2:0] {
    DIV_1,
    DIV_2,
    DIV_3,
    DIV_5,
    DIV_7
  } div_e;

  // Register index of the configuration port
  localparam logic REG_FORMAT = 1'b0;

  // Queue depth between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Weighted sums reach 7 * 255, products of the reciprocal stay below 2^23
  localparam int unsigned NUM_W  = 11;
  localparam int unsigned PROD_W = 23;
  localparam int unsigned RCP_W  = 12;

  // Reciprocals: floor(x / d) == (x * RCP) >> SHIFT over the used range
  localparam logic [RCP_W-1:0] RCP_3   = 12'd683;
  localparam int unsigned      SHIFT_3 = 11;
  localparam logic [RCP_W-1:0] RCP_5   = 12'd1639;
  localparam int unsigned      SHIFT_5 = 13;
  localparam logic [RCP_W-1:0] RCP_7   = 12'd2341;
  localparam int unsigned      SHIFT_7 = 14;

  // One queued item: classified format, expanded endpoints, index words
  typedef struct packed {
    fmt_e        fmt;
    logic        four;   // four-colour palette
    logic [23:0] c0;     // endpoint 0 as {r, g, b}
    logic [23:0] c1;     // endpoint 1 as {r, g, b}
    logic [31:0] cidx;   // 2-bit colour indices
    logic [63:0] alo;    // alpha-style block in the low half
    logic [63:0] ahi;    // alpha-style block in the high half
    logic [31:0] px;     // uncompressed texel as {a, b, g, r}
  } qent_t;

  // Queue write side
  typedef struct packed {
    logic  push;
    qent_t ent;
  } qwr_t;

  // Queue read side
  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qrd_t;

  // Expand a 5-bit channel to 8 bits with rounding
  function automatic logic [7:0] expand5(input logic [4:0] x);
    logic [12:0] t;
    logic [12:0] s;
    t = 13'(x) * 13'd255 + 13'd16;
    s = (t >> 5) + t;
    return s[12:5];
  endfunction

  // Expand a 6-bit channel to 8 bits with rounding
  function automatic logic [7:0] expand6(input logic [5:0] x);
    logic [13:0] t;
    logic [13:0] s;
    t = 14'(x) * 14'd255 + 14'd32;
    s = (t >> 6) + t;
    return s[13:6];
  endfunction

  // Expand RGB565 to {r, g, b}
  function automatic logic [23:0] expand565(input logic [15:0] v);
    return {expand5(v[15:11]), expand6(v[10:5]), expand5(v[4:0])};
  endfunction

  // Divide a weighted sum by a small constant through a reciprocal
  function automatic logic [7:0] div_kind(input logic [NUM_W-1:0] num, input div_e kind);
    logic [RCP_W-1:0]  rcp;
    logic [PROD_W-1:0] prod;
    logic [7:0]        res;
    case (kind)
      DIV_3:   rcp = RCP_3;
      DIV_5:   rcp = RCP_5;
      DIV_7:   rcp = RCP_7;
      default: rcp = '0;
    endcase
    prod = PROD_W'(num) * PROD_W'(rcp);
    case (kind)
      DIV_1:   res = num[7:0];
      DIV_2:   res = num[8:1];
      DIV_3:   res = prod[SHIFT_3 +: 8];
      DIV_5:   res = prod[SHIFT_5 +: 8];
      DIV_7:   res = prod[SHIFT_7 +: 8];
      default: res = num[7:0];
    endcase
    return res;
  endfunction

endpackage

@@ src/bctd_front.sv @@
// ----------------------------------------------------------------------------
// bctd_front
// Accepts input words, classifies them by format, expands colour endpoints
// and pushes one entry per item into the queue. Unused format codes are dropped.
// ----------------------------------------------------------------------------
module bctd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [63:0]        block_low_i,
  input  logic [63:0]        block_high_i,
  input  logic [3:0]         fmt_i,
  input  logic               full_i,
  output bctd_pkg::qwr_t     wr_o
);

  logic        fv_q;
  logic [63:0] lo_q;
  logic [63:0] hi_q;
  logic [3:0]  fmt_q;
  logic        accept;
  logic        drain;
  logic [63:0] cw;
  bctd_pkg::qent_t ent;

  // Stall while the held word cannot move on
  assign in_stall_o = fv_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign drain      = fv_q && !full_i;

  // Hold the accepted word with the format in force at acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (accept) begin
      fv_q <= 1'b1;
    end else if (drain) begin
      fv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_q  <= block_low_i;
      hi_q  <= block_high_i;
      fmt_q <= fmt_i;
    end
  end

  // Classify and build the queue entry
  always_comb begin
    cw          = (fmt_q == bctd_pkg::FMT_BC1) ? lo_q : hi_q;
    ent         = '0;
    ent.fmt     = bctd_pkg::fmt_e'(fmt_q);
    ent.four    = (fmt_q == bctd_pkg::FMT_BC3) || (cw[15:0] > cw[31:16]);
    ent.c0      = bctd_pkg::expand565(cw[15:0]);
    ent.c1      = bctd_pkg::expand565(cw[31:16]);
    ent.cidx    = cw[63:32];
    ent.alo     = lo_q;
    ent.ahi     = hi_q;
    case (fmt_q)
      bctd_pkg::FMT_L8:    ent.px = {8'hFF, lo_q[7:0], lo_q[7:0], lo_q[7:0]};
      bctd_pkg::FMT_A8:    ent.px = {lo_q[7:0], 24'h0};
      bctd_pkg::FMT_R8:    ent.px = {8'hFF, 16'h0, lo_q[7:0]};
      bctd_pkg::FMT_L8A8:  ent.px = {lo_q[15:8], lo_q[7:0], lo_q[7:0], lo_q[7:0]};
      bctd_pkg::FMT_RG8:   ent.px = {8'hFF, 8'h0, lo_q[15:8], lo_q[7:0]};
      bctd_pkg::FMT_RGBA8: ent.px = lo_q[31:0];
      bctd_pkg::FMT_BGRA8: ent.px = {lo_q[31:24], lo_q[7:0], lo_q[15:8], lo_q[23:16]};
      default:             ent.px = '0;
    endcase
  end

  // Push valid formats, drop the rest
  assign wr_o.push = drain && (fmt_q <= bctd_pkg::FMT_BC5);
  assign wr_o.ent  = ent;

endmodule

@@ src/bctd_fifo.sv @@
// ----------------------------------------------------------------------------
// bctd_fifo
// Short queue between front and back; lets either side stall on its own.
// ----------------------------------------------------------------------------
module bctd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bctd_pkg::qwr_t     wr_i,
  output logic               full_o,
  input  logic               pop_i,
  output bctd_pkg::qrd_t     head_o
);

  bctd_pkg::qent_t                  mem_q [bctd_pkg::Q_DEPTH];
  logic [bctd_pkg::Q_PTR_W-1:0]     wptr_q;
  logic [bctd_pkg::Q_PTR_W-1:0]     rptr_q;
  logic [bctd_pkg::Q_CNT_W-1:0]     cnt_q;
  logic                             do_pop;

  assign full_o       = (cnt_q == bctd_pkg::Q_CNT_W'(bctd_pkg::Q_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.ent   = mem_q[rptr_q];
  assign do_pop       = pop_i && head_o.valid;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wptr_q] <= wr_i.ent;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i.push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({wr_i.push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/bctd_back.sv @@
// ----------------------------------------------------------------------------
// bctd_back
// Walks the queue head texel by texel: selects palette weights and sums,
// then divides and registers the texel on the output.
// ----------------------------------------------------------------------------
module bctd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bctd_pkg::qrd_t     head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [7:0]         alpha_o,
  output logic [1:0]         texel_col_o,
  output logic [1:0]         texel_row_o,
  output logic               last_texel_o
);

  typedef struct packed {
    logic [bctd_pkg::NUM_W-1:0] num;
    bctd_pkg::div_e             kind;
  } wsum_t;

  typedef struct packed {
    wsum_t [3:0] ch;    // 0 red, 1 green, 2 blue, 3 alpha
    logic  [1:0] col;
    logic  [1:0] row;
    logic        last;
  } s1_t;

  logic        adv;
  logic [3:0]  cnt_q;
  logic        s1_valid_q;
  s1_t         s1_q;
  s1_t         s1_d;
  logic        item_last;
  logic        out_valid_q;
  logic [7:0]  red_q;
  logic [7:0]  green_q;
  logic [7:0]  blue_q;
  logic [7:0]  alpha_q;
  logic [1:0]  col_q;
  logic [1:0]  row_q;
  logic        last_q;

  // Weighted sum of one alpha-style palette entry
  function automatic wsum_t alpha_sum(input logic [7:0] a0, input logic [7:0] a1,
                                      input logic [2:0] i);
    wsum_t r;
    logic [2:0] w0;
    logic [2:0] w1;
    w0 = '0;
    w1 = i - 3'd1;
    r.num  = '0;
    r.kind = bctd_pkg::DIV_1;
    if (i == 3'd0) begin
      r.num = bctd_pkg::NUM_W'(a0);
    end else if (i == 3'd1) begin
      r.num = bctd_pkg::NUM_W'(a1);
    end else if (a0 > a1) begin
      w0     = 3'(4'd8 - {1'b0, i});
      r.num  = bctd_pkg::NUM_W'(a0) * bctd_pkg::NUM_W'(w0)
             + bctd_pkg::NUM_W'(a1) * bctd_pkg::NUM_W'(w1);
      r.kind = bctd_pkg::DIV_7;
    end else if (i == 3'd6) begin
      r.num = '0;
    end else if (i == 3'd7) begin
      r.num = bctd_pkg::NUM_W'(8'hFF);
    end else begin
      w0     = 3'd6 - i;
      r.num  = bctd_pkg::NUM_W'(a0) * bctd_pkg::NUM_W'(w0)
             + bctd_pkg::NUM_W'(a1) * bctd_pkg::NUM_W'(w1);
      r.kind = bctd_pkg::DIV_5;
    end
    return r;
  endfunction

  // Whole pipeline moves when the output register is free or being taken
  assign adv       = !out_valid_q || !out_stall_i;
  assign item_last = (head_i.ent.fmt < bctd_pkg::FMT_BC1) || (cnt_q == 4'd15);
  assign pop_o     = adv && head_i.valid && item_last;

  // Select palette entry sums for the current texel
  always_comb begin
    bctd_pkg::qent_t h;
    logic [1:0]      ci;
    logic [5:0]      aoff;
    logic [2:0]      ilo;
    logic [2:0]      ihi;
    wsum_t           slo;
    wsum_t           shi;
    logic [7:0]      e0;
    logic [7:0]      e1;
    h    = head_i.ent;
    ci   = h.cidx[{cnt_q, 1'b0} +: 2];
    aoff = 6'(cnt_q) * 6'd3;
    ilo  = h.alo[6'd16 + aoff +: 3];
    ihi  = h.ahi[6'd16 + aoff +: 3];
    slo  = alpha_sum(h.alo[7:0], h.alo[15:8], ilo);
    shi  = alpha_sum(h.ahi[7:0], h.ahi[15:8], ihi);
    s1_d      = '0;
    s1_d.col  = cnt_q[1:0];
    s1_d.row  = cnt_q[3:2];
    s1_d.last = item_last;
    for (int c = 0; c < 4; c++) begin
      s1_d.ch[c].kind = bctd_pkg::DIV_1;
    end
    s1_d.ch[3].num = bctd_pkg::NUM_W'(8'hFF);
    case (h.fmt)
      bctd_pkg::FMT_BC1, bctd_pkg::FMT_BC3: begin
        for (int c = 0; c < 3; c++) begin
          e0 = h.c0[8 * (2 - c) +: 8];
          e1 = h.c1[8 * (2 - c) +: 8];
          case (ci)
            2'd0: s1_d.ch[c].num = bctd_pkg::NUM_W'(e0);
            2'd1: s1_d.ch[c].num = bctd_pkg::NUM_W'(e1);
            2'd2: begin
              if (h.four) begin
                s1_d.ch[c].num  = bctd_pkg::NUM_W'({e0, 1'b0}) + bctd_pkg::NUM_W'(e1);
                s1_d.ch[c].kind = bctd_pkg::DIV_3;
              end else begin
                s1_d.ch[c].num  = bctd_pkg::NUM_W'(e0) + bctd_pkg::NUM_W'(e1);
                s1_d.ch[c].kind = bctd_pkg::DIV_2;
              end
            end
            default: begin
              if (h.four) begin
                s1_d.ch[c].num  = bctd_pkg::NUM_W'(e0) + bctd_pkg::NUM_W'({e1, 1'b0});
                s1_d.ch[c].kind = bctd_pkg::DIV_3;
              end else begin
                s1_d.ch[c].num = '0;
              end
            end
          endcase
        end
        if (h.fmt == bctd_pkg::FMT_BC3) begin
          s1_d.ch[3] = slo;
        end else if (ci == 2'd3 && !h.four) begin
          s1_d.ch[3].num = '0;
        end
      end
      bctd_pkg::FMT_BC4: begin
        s1_d.ch[0] = slo;
        s1_d.ch[1] = slo;
        s1_d.ch[2] = slo;
      end
      bctd_pkg::FMT_BC5: begin
        s1_d.ch[0] = slo;
        s1_d.ch[1] = shi;
        s1_d.ch[2].num = '0;
      end
      default: begin
        s1_d.col = '0;
        s1_d.row = '0;
        for (int c = 0; c < 4; c++) begin
          s1_d.ch[c].num = bctd_pkg::NUM_W'(h.px[8 * c +: 8]);
        end
      end
    endcase
  end

  // Step the texel counter, restart on the last texel of an item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= head_i.valid;
      out_valid_q <= s1_valid_q;
      if (head_i.valid) begin
        cnt_q <= item_last ? 4'd0 : cnt_q + 4'd1;
      end
    end
  end

  // Divide and register the output word
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q    <= s1_d;
      red_q   <= bctd_pkg::div_kind(s1_q.ch[0].num, s1_q.ch[0].kind);
      green_q <= bctd_pkg::div_kind(s1_q.ch[1].num, s1_q.ch[1].kind);
      blue_q  <= bctd_pkg::div_kind(s1_q.ch[2].num, s1_q.ch[2].kind);
      alpha_q <= bctd_pkg::div_kind(s1_q.ch[3].num, s1_q.ch[3].kind);
      col_q   <= s1_q.col;
      row_q   <= s1_q.row;
      last_q  <= s1_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign alpha_o      = alpha_q;
  assign texel_col_o  = col_q;
  assign texel_row_o  = row_q;
  assign last_texel_o = last_q;

endmodule

@@ src/bc_texture_block_decoder.sv @@
// An accepted word passes the front register, the queue, the sum stage and the output.
// Compressed blocks (BC1/BC3/BC4/BC5) give 16 texels each, one texel per
//   cycle while the output is not stalled, stepped by the back end's texel
//   counter; uncompressed formats give one texel per word.
// Reset: clears all valid flags, the queue and the format register (L8).
// ----------------------------------------------------------------------------
// bc_texture_block_decoder
// Decodes BC1/BC3/BC4/BC5 blocks and uncompressed texels to RGBA8 words.
// ----------------------------------------------------------------------------
module bc_texture_block_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [1:0]  texel_col_o,
  output logic [1:0]  texel_row_o,
  output logic        last_texel_o
);

  logic [3:0]      fmt_q;
  logic            full;
  logic            pop;
  bctd_pkg::qwr_t  qwr;
  bctd_pkg::qrd_t  qrd;

  // Format register write and readback
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= bctd_pkg::FMT_L8;
    end else if (psel && penable && pwrite && pready && paddr[2] == bctd_pkg::REG_FORMAT) begin
      fmt_q <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == bctd_pkg::REG_FORMAT) ? {28'h0, fmt_q} : 32'h0;

  bctd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .block_low_i  (block_low_i),
    .block_high_i (block_high_i),
    .fmt_i        (fmt_q),
    .full_i       (full),
    .wr_o         (qwr)
  );

  bctd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (qwr),
    .full_o (full),
    .pop_i  (pop),
    .head_o (qrd)
  );

  bctd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (qrd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .texel_col_o  (texel_col_o),
    .texel_row_o  (texel_row_o),
    .last_texel_o (last_texel_o)
  );

endmodule

@@ src/bctd_checker.sv @@
// ----------------------------------------------------------------------------
// bctd_checker
// Port-level checks of the decoder's output sequence, bound to the top level.
// ----------------------------------------------------------------------------
module bctd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic [7:0] alpha_o,
  input logic [1:0] texel_col_o,
  input logic [1:0] texel_row_o,
  input logic       last_texel_o
);

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_o) && $stable(green_o)
      && $stable(blue_o) && $stable(alpha_o) && $stable(last_texel_o))
    else $error("stalled output word changed");

  // Texels of a block follow in raster order without gaps
  a_raster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_texel_o |=> out_valid_o
      && ({texel_row_o, texel_col_o} == $past({texel_row_o, texel_col_o}) + 4'd1))
    else $error("texel sequence broken");

  // An item ends on its single texel or on the bottom-right texel
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_texel_o |->
      (texel_col_o == 2'd3 && texel_row_o == 2'd3)
      || (texel_col_o == 2'd0 && texel_row_o == 2'd0))
    else $error("last texel at wrong position");

endmodule

bind bc_texture_block_decoder bctd_checker u_bctd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .red_o        (red_o),
  .green_o      (green_o),
  .blue_o       (blue_o),
  .alpha_o      (alpha_o),
  .texel_col_o  (texel_col_o),
  .texel_row_o  (texel_row_o),
  .last_texel_o (last_texel_o)
);
